/* hdl/kfd_pkg.sv */
// Shared types, constants and the arctangent table for the keyframe trigger decider.
// No dependencies; every other file imports this package.
`default_nettype none

package kfd_pkg;

  // Default pipeline parameters
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_ANGLE_BITS   = 16;

  // Field widths
  localparam int POS_W   = 24;
  localparam int ROT_W   = 16;
  localparam int STAMP_W = 48;
  localparam int Q16_W   = 32;
  localparam int YAW_W   = 16;
  localparam int ID_W    = 32;
  localparam int SQ_W    = 2 * POS_W + 1;  // square of a 25-bit difference

  // CORDIC datapath: Q1.14 input scaled by 256 plus headroom for gain and sign
  localparam int CORDIC_PRESCALE = 8;
  localparam int CW = ROT_W + CORDIC_PRESCALE + 3;

  // Stream packing
  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 40;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HES_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLES   = 3'd5;

  // Configuration reset values
  localparam logic [15:0] DEF_TRANS_THR = 16'd500;
  localparam logic [31:0] DEF_TRANS_SQ  = 32'd250000;
  localparam logic [15:0] DEF_YAW_THR   = 16'd1820;
  localparam logic [31:0] DEF_TIME_THR  = 32'd1000000;
  localparam logic [31:0] DEF_HES_MIN   = 32'd0;
  localparam logic [31:0] DEF_SIG_MIN   = 32'hFFFF_FFFF;
  localparam logic [2:0]  DEF_ENABLES   = 3'd7;

  // Trigger enable bits
  localparam int EN_DEGRADED = 0;
  localparam int EN_HESSIAN  = 1;
  localparam int EN_SIGMA    = 2;

  typedef enum logic [2:0] {
    RSN_NONE      = 3'd0,
    RSN_BOOTSTRAP = 3'd1,
    RSN_TRANS     = 3'd2,
    RSN_YAW       = 3'd3,
    RSN_TIME      = 3'd4,
    RSN_DEGRADED  = 3'd5,
    RSN_HESSIAN   = 3'd6,
    RSN_SIGMA     = 3'd7
  } reason_e;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [STAMP_W-1:0]      stamp_us;
    logic                    degraded;
    logic [Q16_W-1:0]        hessian_eig;
    logic [Q16_W-1:0]        pos_sigma;
  } item_t;

  typedef struct packed {
    item_t              item;
    logic [YAW_W-1:0]   yaw;
  } cand_t;

  typedef struct packed {
    logic [31:0] trans_sq;
    logic [15:0] yaw_thr;
    logic [31:0] time_thr;
    logic [31:0] hes_min;
    logic [31:0] sig_min;
    logic [2:0]  enables;
  } cfg_t;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURN32 [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // Table entry rounded to nearest at the given angle resolution
  function automatic logic [31:0] atan_entry(input int i, input int ab);
    int          idx;
    int          sh;
    logic [32:0] v;
    idx = (i < 24) ? i : 23;
    sh  = (ab >= 32) ? 0 : 32 - ab;
    v   = {1'b0, ATAN_TURN32[idx]};
    if (sh == 0) begin
      return v[31:0];
    end
    v = v + (33'd1 << (sh - 1));
    return 32'(v >> sh);
  endfunction

endpackage

`default_nettype wire

/* hdl/kfd_cordic.sv */
// Pipelined vectoring CORDIC: yaw of (rot_cos, rot_sin) in 16-bit binary angle units.
// An input stage, then one rotation step per stage; the candidate fields ride alongside. Uses kfd_pkg.
`default_nettype none

module kfd_cordic import kfd_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int ANGLE_BITS   = DEF_ANGLE_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_valid_i,
  output logic                         s_ready_o,
  input  wire item_t                   s_item_i,
  input  wire logic signed [ROT_W-1:0] s_cos_i,
  input  wire logic signed [ROT_W-1:0] s_sin_i,
  output logic                         m_valid_o,
  input  wire logic                    m_ready_i,
  output cand_t                        m_cand_o
);

  localparam int N = CORDIC_STEPS;

  logic signed [CW-1:0]     x_q    [N+1];
  logic signed [CW-1:0]     y_q    [N+1];
  logic [ANGLE_BITS-1:0]    z_q    [N+1];
  item_t                    item_q [N+1];
  logic [N:0]               zero_q;
  logic [N:0]               valid_q;
  logic [N+1:0]             rdy;

  // Stage ready: a stage moves when it is empty or its successor moves
  assign rdy[N+1] = m_ready_i;
  for (genvar k = 0; k <= N; k++) begin : g_rdy
    assign rdy[k] = !valid_q[k] || rdy[k+1];
  end
  assign s_ready_o = rdy[0];

  // Stage 0: prescale and fold the left half-plane onto the right
  logic signed [CW-1:0]  x0, y0;
  logic [ANGLE_BITS-1:0] z0;
  always_comb begin
    x0 = {{(CW-ROT_W-CORDIC_PRESCALE){s_cos_i[ROT_W-1]}}, s_cos_i, {CORDIC_PRESCALE{1'b0}}};
    y0 = {{(CW-ROT_W-CORDIC_PRESCALE){s_sin_i[ROT_W-1]}}, s_sin_i, {CORDIC_PRESCALE{1'b0}}};
    z0 = '0;
    if (s_cos_i[ROT_W-1]) begin
      x0 = -x0;
      y0 = -y0;
      z0 = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      valid_q[0] <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_valid_i) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      z_q[0]    <= z0;
      item_q[0] <= s_item_i;
      zero_q[0] <= (s_cos_i == '0) && (s_sin_i == '0);
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [ANGLE_BITS-1:0] ENT = ANGLE_BITS'(atan_entry(k, ANGLE_BITS));
    logic signed [CW-1:0]  xs, ys, x_d, y_d;
    logic [ANGLE_BITS-1:0] z_d;
    logic                  up;

    always_comb begin
      xs = x_q[k] >>> k;
      ys = y_q[k] >>> k;
      up = !y_q[k][CW-1] && (y_q[k] != '0);
      if (up) begin
        x_d = x_q[k] + ys;
        y_d = y_q[k] - xs;
        z_d = z_q[k] + ENT;
      end else begin
        x_d = x_q[k] - ys;
        y_d = y_q[k] + xs;
        z_d = z_q[k] - ENT;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (rdy[k+1]) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k+1] && valid_q[k]) begin
        x_q[k+1]    <= x_d;
        y_q[k+1]    <= y_d;
        z_q[k+1]    <= z_d;
        item_q[k+1] <= item_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  // Bring the angle to 16 bits per turn
  logic [YAW_W-1:0] yaw16;
  if (ANGLE_BITS > YAW_W) begin : g_round
    localparam int SH = ANGLE_BITS - YAW_W;
    logic [ANGLE_BITS-1:0] zr;
    assign zr    = z_q[N] + ANGLE_BITS'(1 << (SH - 1));
    assign yaw16 = zr[ANGLE_BITS-1:SH];
  end else if (ANGLE_BITS == YAW_W) begin : g_same
    assign yaw16 = z_q[N];
  end else begin : g_widen
    assign yaw16 = {z_q[N], {(YAW_W-ANGLE_BITS){1'b0}}};
  end

  assign m_valid_o     = valid_q[N];
  assign m_cand_o.item = item_q[N];
  assign m_cand_o.yaw  = zero_q[N] ? '0 : yaw16;

endmodule

`default_nettype wire

/* hdl/kfd_decide.sv */
// Trigger evaluation, keyframe/observation state and the result register.
// Squared distances are staged against both the stored keyframe and the preceding
// candidate, so a keyframe made by the item just ahead is seen without a stall. Uses kfd_pkg.
`default_nettype none

module kfd_decide import kfd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  s_valid_i,
  output logic       s_ready_o,
  input  wire cand_t s_cand_i,
  output logic       m_valid_o,
  input  wire logic  m_ready_i,
  output logic       m_create_o,
  output reason_e    m_reason_o,
  output logic [ID_W-1:0] m_id_o
);

  // Prep stage
  logic            p_valid_q;
  cand_t           p_cand_q;
  logic [SQ_W-2:0] sqx_kf_q, sqy_kf_q, sqx_pv_q, sqy_pv_q;

  // Keyframe and observation state
  logic                    have_kf_q;
  logic signed [POS_W-1:0] kf_x_q, kf_y_q;
  logic [YAW_W-1:0]        kf_yaw_q;
  logic [STAMP_W-1:0]      kf_stamp_q;
  logic [ID_W-1:0]         next_id_q;
  logic                    obs_valid_q, obs_deg_q;
  logic [Q16_W-1:0]        obs_hes_q, obs_sig_q;

  // Most recently committed candidate
  logic signed [POS_W-1:0] li_x_q, li_y_q;
  logic                    li_created_q;

  // Result register
  logic            o_valid_q;
  logic            o_create_q;
  reason_e         o_reason_q;
  logic [ID_W-1:0] o_id_q;

  logic commit, load;
  assign commit    = p_valid_q && (!o_valid_q || m_ready_i);
  assign s_ready_o = !p_valid_q || commit;
  assign load      = s_valid_i && s_ready_o;

  // Distances of the incoming candidate
  logic signed [POS_W-1:0] pv_x, pv_y;
  logic signed [POS_W:0]   dx_kf, dy_kf, dx_pv, dy_pv;
  logic signed [SQ_W:0]    px_kf, py_kf, px_pv, py_pv;

  always_comb begin
    // The item ahead is still in the prep stage or already committed
    pv_x  = p_valid_q ? p_cand_q.item.pos_x : li_x_q;
    pv_y  = p_valid_q ? p_cand_q.item.pos_y : li_y_q;
    dx_kf = {s_cand_i.item.pos_x[POS_W-1], s_cand_i.item.pos_x} - {kf_x_q[POS_W-1], kf_x_q};
    dy_kf = {s_cand_i.item.pos_y[POS_W-1], s_cand_i.item.pos_y} - {kf_y_q[POS_W-1], kf_y_q};
    dx_pv = {s_cand_i.item.pos_x[POS_W-1], s_cand_i.item.pos_x} - {pv_x[POS_W-1], pv_x};
    dy_pv = {s_cand_i.item.pos_y[POS_W-1], s_cand_i.item.pos_y} - {pv_y[POS_W-1], pv_y};
    px_kf = dx_kf * dx_kf;
    py_kf = dy_kf * dy_kf;
    px_pv = dx_pv * dx_pv;
    py_pv = dy_pv * dy_pv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (s_ready_o) begin
      p_valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      p_cand_q <= s_cand_i;
      sqx_kf_q <= px_kf[SQ_W-2:0];
      sqy_kf_q <= py_kf[SQ_W-2:0];
      sqx_pv_q <= px_pv[SQ_W-2:0];
      sqy_pv_q <= py_pv[SQ_W-2:0];
    end
  end

  // Trigger checks in priority order
  logic [SQ_W-1:0]    d2;
  logic [YAW_W-1:0]   dyaw;
  logic [YAW_W:0]     adyaw;
  logic [STAMP_W-1:0] dt;
  logic               hit_trans, hit_yaw, hit_time, hit_deg, hit_hes, hit_sig;
  reason_e            reason;
  item_t              it;

  always_comb begin
    it   = p_cand_q.item;
    // Previous item made a keyframe: that item's position is the reference
    d2   = li_created_q ? ({1'b0, sqx_pv_q} + {1'b0, sqy_pv_q})
                        : ({1'b0, sqx_kf_q} + {1'b0, sqy_kf_q});
    dyaw  = p_cand_q.yaw - kf_yaw_q;
    adyaw = dyaw[YAW_W-1] ? ((YAW_W+1)'(1 << YAW_W) - {1'b0, dyaw}) : {1'b0, dyaw};
    dt    = (it.stamp_us >= kf_stamp_q) ? (it.stamp_us - kf_stamp_q) : '0;

    hit_trans = d2 >= {{(SQ_W-32){1'b0}}, cfg_i.trans_sq};
    hit_yaw   = adyaw >= {1'b0, cfg_i.yaw_thr};
    hit_time  = dt >= {{(STAMP_W-32){1'b0}}, cfg_i.time_thr};
    hit_deg   = cfg_i.enables[EN_DEGRADED] && it.degraded && (!obs_valid_q || !obs_deg_q);
    hit_hes   = cfg_i.enables[EN_HESSIAN] && (it.hessian_eig <= cfg_i.hes_min)
                && (!obs_valid_q || (obs_hes_q > cfg_i.hes_min));
    hit_sig   = cfg_i.enables[EN_SIGMA] && (it.pos_sigma >= cfg_i.sig_min)
                && (!obs_valid_q || (obs_sig_q < cfg_i.sig_min));

    priority if (!have_kf_q) reason = RSN_BOOTSTRAP;
    else if (hit_trans)      reason = RSN_TRANS;
    else if (hit_yaw)        reason = RSN_YAW;
    else if (hit_time)       reason = RSN_TIME;
    else if (hit_deg)        reason = RSN_DEGRADED;
    else if (hit_hes)        reason = RSN_HESSIAN;
    else if (hit_sig)        reason = RSN_SIGMA;
    else                     reason = RSN_NONE;
  end

  logic create;
  assign create = (reason != RSN_NONE);

  // State update on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_kf_q    <= 1'b0;
      kf_x_q       <= '0;
      kf_y_q       <= '0;
      kf_yaw_q     <= '0;
      kf_stamp_q   <= '0;
      next_id_q    <= ID_W'(1);
      obs_valid_q  <= 1'b0;
      obs_deg_q    <= 1'b0;
      obs_hes_q    <= '0;
      obs_sig_q    <= '0;
      li_x_q       <= '0;
      li_y_q       <= '0;
      li_created_q <= 1'b0;
    end else if (commit) begin
      obs_valid_q  <= 1'b1;
      obs_deg_q    <= it.degraded;
      obs_hes_q    <= it.hessian_eig;
      obs_sig_q    <= it.pos_sigma;
      li_x_q       <= it.pos_x;
      li_y_q       <= it.pos_y;
      li_created_q <= create;
      if (create) begin
        have_kf_q  <= 1'b1;
        kf_x_q     <= it.pos_x;
        kf_y_q     <= it.pos_y;
        kf_yaw_q   <= p_cand_q.yaw;
        kf_stamp_q <= it.stamp_us;
        next_id_q  <= next_id_q + ID_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (!o_valid_q || m_ready_i) begin
      o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      o_create_q <= create;
      o_reason_q <= reason;
      o_id_q     <= create ? next_id_q : '0;
    end
  end

  assign m_valid_o  = o_valid_q;
  assign m_create_o = o_create_q;
  assign m_reason_o = o_reason_q;
  assign m_id_o     = o_id_q;

endmodule

`default_nettype wire

/* hdl/keyframe_trigger_decider.sv */
// Depth: the CORDIC pipeline (an input stage, then one rotation step per stage), then the
// prep and result stages. Throughput: one item per cycle while the result is not stalled;
// stages advance independently, so bubbles absorb stalls.
// Reset (rst_ni low, asynchronous) empties the pipeline, clears the keyframe and
// observation state (next id back to 1) and restores all configuration defaults.
// Top level: configuration registers, stream packing; uses kfd_pkg, kfd_cordic, kfd_decide.
`default_nettype none

module keyframe_trigger_decider import kfd_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int ANGLE_BITS   = DEF_ANGLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]            cfg_wdata_i,
  // Candidate stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // pos_x[23:0] pos_y[47:24] rot_cos[63:48] rot_sin[79:64] stamp_us[127:80]
  // degraded[128] hessian_eig[160:129] position sigma[192:161], zero pad[199:193]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Decision stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // create[0] reason_code[3:1] keyframe_id[35:4], zero pad[39:36]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trans_sq <= DEF_TRANS_SQ;
      cfg_q.yaw_thr  <= DEF_YAW_THR;
      cfg_q.time_thr <= DEF_TIME_THR;
      cfg_q.hes_min  <= DEF_HES_MIN;
      cfg_q.sig_min  <= DEF_SIG_MIN;
      cfg_q.enables  <= DEF_ENABLES;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        // Hold the threshold squared; the distance compare works on squares
        CFG_TRANS_THR: cfg_q.trans_sq <= 32'(cfg_wdata_i[15:0]) * 32'(cfg_wdata_i[15:0]);
        CFG_YAW_THR:   cfg_q.yaw_thr  <= cfg_wdata_i[15:0];
        CFG_TIME_THR:  cfg_q.time_thr <= cfg_wdata_i;
        CFG_HES_MIN:   cfg_q.hes_min  <= cfg_wdata_i;
        CFG_SIG_MIN:   cfg_q.sig_min  <= cfg_wdata_i;
        CFG_ENABLES:   cfg_q.enables  <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  item_t                   in_item;
  logic signed [ROT_W-1:0] in_cos, in_sin;

  always_comb begin
    in_item.pos_x       = s_axis_tdata[23:0];
    in_item.pos_y       = s_axis_tdata[47:24];
    in_item.stamp_us    = s_axis_tdata[127:80];
    in_item.degraded    = s_axis_tdata[128];
    in_item.hessian_eig = s_axis_tdata[160:129];
    in_item.pos_sigma   = s_axis_tdata[192:161];
    in_cos              = s_axis_tdata[63:48];
    in_sin              = s_axis_tdata[79:64];
  end

  logic  yaw_valid, yaw_ready;
  cand_t yaw_cand;

  kfd_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (in_item),
    .s_cos_i   (in_cos),
    .s_sin_i   (in_sin),
    .m_valid_o (yaw_valid),
    .m_ready_i (yaw_ready),
    .m_cand_o  (yaw_cand)
  );

  logic            res_create;
  reason_e         res_reason;
  logic [ID_W-1:0] res_id;

  kfd_decide u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s_valid_i  (yaw_valid),
    .s_ready_o  (yaw_ready),
    .s_cand_i   (yaw_cand),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_create_o (res_create),
    .m_reason_o (res_reason),
    .m_id_o     (res_id)
  );

  assign m_axis_tdata = {4'b0000, res_id, res_reason, res_create};

endmodule

`default_nettype wire

/* hdl/kfd_checker.sv */
// Port-level checks for keyframe_trigger_decider, attached by bind.
// Sees only the top-level ports; uses kfd_pkg for widths.
`default_nettype none

module kfd_checker import kfd_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   cfg_we_i,
  input wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input wire logic [31:0]            cfg_wdata_i,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No keyframe: reason and id read zero
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_TDATA_W-1:1] == '0)
    else $error("non-keyframe result carries reason or id");

  // A keyframe always carries a reason
  a_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3:1] != RSN_NONE)
    else $error("keyframe without reason");

  // Reset empties the result stage
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind keyframe_trigger_decider kfd_checker u_kfd_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for keyframe_trigger_decider: streams candidate poses,
// predicts every decision in a scoreboard class and compares it field by field.
// Depends on kfd_pkg (register indexes, reason codes) and the DUT top level.

module testbench;
  import kfd_pkg::*;

  localparam int CORDIC_STEPS  = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int LATENCY       = CORDIC_STEPS + 2;
  localparam int SETTLE_CYCLES = LATENCY + 4;
  localparam int QUIET_LIMIT   = 2000;

  // Indexes outside the register map; the block must ignore them
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  // Candidate transaction, lowest field last
  typedef struct packed {
    logic [6:0]         pad;
    logic [31:0]        pos_sigma;
    logic [31:0]        hessian_eig;
    logic               degraded;
    logic [47:0]        stamp_us;
    logic signed [15:0] rot_sin;
    logic signed [15:0] rot_cos;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_x;
  } candidate_t;

  // Decision transaction, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] keyframe_id;
    reason_e     reason;
    logic        create;
  } decision_t;

  class decision_board;
    localparam int STEPS = 16;

    logic [15:0] trans_thr;
    logic [15:0] yaw_thr;
    logic [31:0] time_thr;
    logic [31:0] hes_min;
    logic [31:0] sig_min;
    logic [2:0]  enables;

    logic        have_kf;
    longint      last_x;
    longint      last_y;
    logic [15:0] last_yaw;
    logic [47:0] last_stamp;
    logic [31:0] next_id;
    logic        obs_valid;
    logic        obs_degraded;
    logic [31:0] obs_hessian;
    logic [31:0] obs_sigma;

    logic [31:0] arc_turn32 [16];
    decision_t   expected [$];
    int unsigned failures;
    int unsigned noted;
    int unsigned per_reason [8];

    function new();
      arc_turn32 = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                     32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                     32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                     32'd166886, 32'd83443, 32'd41722, 32'd20861};
      trans_thr    = 16'd500;
      yaw_thr      = 16'd1820;
      time_thr     = 32'd1000000;
      hes_min      = 32'd0;
      sig_min      = 32'hFFFF_FFFF;
      enables      = 3'd7;
      have_kf      = 1'b0;
      last_x       = 0;
      last_y       = 0;
      last_yaw     = '0;
      last_stamp   = '0;
      next_id      = 32'd1;
      obs_valid    = 1'b0;
      obs_degraded = 1'b0;
      obs_hessian  = '0;
      obs_sigma    = '0;
      failures     = 0;
      noted        = 0;
      foreach (per_reason[i]) per_reason[i] = 0;
    endfunction

    function void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_TRANS_THR: trans_thr = val[15:0];
        CFG_YAW_THR:   yaw_thr   = val[15:0];
        CFG_TIME_THR:  time_thr  = val;
        CFG_HES_MIN:   hes_min   = val;
        CFG_SIG_MIN:   sig_min   = val;
        CFG_ENABLES:   enables   = val[2:0];
        default: ;
      endcase
    endfunction

    // Vectoring CORDIC: atan2(s, c) in 16-bit binary angle units
    function logic [15:0] heading(logic signed [15:0] c, logic signed [15:0] s);
      longint      x;
      longint      y;
      longint      xs;
      longint      ys;
      logic [15:0] z;
      logic [32:0] wide;
      if (c == 0 && s == 0) return '0;
      x = longint'(c) * 256;
      y = longint'(s) * 256;
      z = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 16'h8000;
      end
      for (int i = 0; i < STEPS; i++) begin
        xs   = x >>> i;
        ys   = y >>> i;
        wide = {1'b0, arc_turn32[i]} + 33'h0_0000_8000;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + wide[31:16];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - wide[31:16];
        end
      end
      return z;
    endfunction

    function void note_candidate(candidate_t c);
      logic [15:0] yaw;
      logic [15:0] dyaw;
      logic [16:0] mag;
      longint      dx;
      longint      dy;
      logic [63:0] d2;
      logic [63:0] t2;
      logic [47:0] dt;
      reason_e     why;
      decision_t   d;
      yaw = heading(c.rot_cos, c.rot_sin);
      why = RSN_NONE;
      if (!have_kf) begin
        why = RSN_BOOTSTRAP;
      end else begin
        dx   = longint'(c.pos_x) - last_x;
        dy   = longint'(c.pos_y) - last_y;
        d2   = dx * dx + dy * dy;
        t2   = 64'(trans_thr) * 64'(trans_thr);
        dyaw = yaw - last_yaw;
        mag  = dyaw[15] ? 17'h10000 - {1'b0, dyaw} : {1'b0, dyaw};
        dt   = (c.stamp_us >= last_stamp) ? c.stamp_us - last_stamp : '0;
        if (d2 >= t2) why = RSN_TRANS;
        else if (mag >= yaw_thr) why = RSN_YAW;
        else if (dt >= time_thr) why = RSN_TIME;
        else if (enables[EN_DEGRADED] && c.degraded && (!obs_valid || !obs_degraded))
          why = RSN_DEGRADED;
        else if (enables[EN_HESSIAN] && c.hessian_eig <= hes_min &&
                 (!obs_valid || obs_hessian > hes_min))
          why = RSN_HESSIAN;
        else if (enables[EN_SIGMA] && c.pos_sigma >= sig_min &&
                 (!obs_valid || obs_sigma < sig_min))
          why = RSN_SIGMA;
      end

      // Observation follows every candidate, keyframe or not
      obs_valid    = 1'b1;
      obs_degraded = c.degraded;
      obs_hessian  = c.hessian_eig;
      obs_sigma    = c.pos_sigma;

      d.pad = '0;
      if (why != RSN_NONE) begin
        d.create      = 1'b1;
        d.reason      = why;
        d.keyframe_id = next_id;
        next_id       = next_id + 32'd1;
        have_kf       = 1'b1;
        last_x        = longint'(c.pos_x);
        last_y        = longint'(c.pos_y);
        last_yaw      = yaw;
        last_stamp    = c.stamp_us;
      end else begin
        d.create      = 1'b0;
        d.reason      = RSN_NONE;
        d.keyframe_id = '0;
      end
      expected = {expected, d};
      per_reason[int'(why)]++;
      noted++;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    task report(string msg);
      failures++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_decision(decision_t got);
      decision_t want;
      if (expected.size() == 0) begin
        report($sformatf("decision %h arrived with none pending", got));
        return;
      end
      want = expected.pop_front();
      if (got.create !== want.create)
        report($sformatf("create %b, predicted %b", got.create, want.create));
      if (got.reason !== want.reason)
        report($sformatf("reason %0d, predicted %0d", got.reason, want.reason));
      if (got.keyframe_id !== want.keyframe_id)
        report($sformatf("keyframe id %0d, predicted %0d", got.keyframe_id,
                         want.keyframe_id));
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [31:0]           cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // pos_x pos_y rot_cos rot_sin stamp_us degraded hessian_eig position sigma pad
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // create reason_code keyframe_id pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  decision_board board;
  int  quiet_cycles  = 0;
  int  settings_used = 0;
  bit  sender_calm   = 1'b0;

  // Random walk that keeps most candidates close to the last keyframe
  logic signed [23:0] walk_x   = '0;
  logic signed [23:0] walk_y   = '0;
  logic signed [15:0] walk_c   = 16'sd16384;
  logic signed [15:0] walk_s   = '0;
  logic [47:0]        walk_t   = '0;
  logic               walk_deg = 1'b0;
  logic [31:0]        walk_hes = '0;
  logic [31:0]        walk_sig = '0;

  keyframe_trigger_decider #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      board.note_candidate(candidate_t'(s_axis_tdata));
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_decision(decision_t'(m_axis_tdata));
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: bursts of ready with mostly short stalls, now and then a long one
  initial begin
    int burst;
    int stall;
    int r;
    forever begin
      @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 5) begin
        burst = 60;
        stall = 0;
      end else begin
        burst = $urandom_range(1, 8);
        r     = $urandom_range(0, 99);
        if (r < 40) stall = 0;
        else if (r < 90) stall = $urandom_range(1, 3);
        else stall = $urandom_range(10, 40);
      end
      m_axis_tready <= 1'b1;
      repeat (burst - 1) @(posedge clk_i);
      if (stall > 0) begin
        @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk_i);
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic candidate_t pose(input logic signed [23:0] px, py,
                                      input logic signed [15:0] rc, rs,
                                      input logic [47:0] t, input logic dg,
                                      input logic [31:0] h, sg);
    candidate_t c;
    c.pad         = '0;
    c.pos_x       = px;
    c.pos_y       = py;
    c.rot_cos     = rc;
    c.rot_sin     = rs;
    c.stamp_us    = t;
    c.degraded    = dg;
    c.hessian_eig = h;
    c.pos_sigma   = sg;
    return c;
  endfunction

  task automatic send_candidate(input candidate_t c);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and hold until every predicted decision has come back
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.apply_setting(idx, val);
  endtask

  task automatic random_candidate(output candidate_t c);
    int          kind;
    int          spread;
    int          nc;
    int          ns;
    int          r;
    logic [31:0] tspread;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // Noise: every field but the pad random over its full width
      c.pad         = '0;
      c.pos_x       = 24'($urandom);
      c.pos_y       = 24'($urandom);
      c.rot_cos     = 16'($urandom);
      c.rot_sin     = 16'($urandom);
      c.stamp_us    = {16'($urandom), 32'($urandom)};
      c.degraded    = 1'($urandom);
      c.hessian_eig = $urandom;
      c.pos_sigma   = $urandom;
      return;
    end
    if (kind < 18) begin
      walk_x = 24'($urandom);
      walk_y = 24'($urandom);
      walk_c = 16'(int'($urandom_range(0, 32768)) - 16384);
      walk_s = 16'(int'($urandom_range(0, 32768)) - 16384);
      if ($urandom_range(0, 1) == 1) walk_t = {16'($urandom), 32'($urandom)};
    end else begin
      spread = int'(board.trans_thr) / 6 + 4;
      walk_x = walk_x + 24'(int'($urandom_range(0, 2 * spread)) - spread);
      walk_y = walk_y + 24'(int'($urandom_range(0, 2 * spread)) - spread);
      spread = int'(board.yaw_thr) / 4 + 2;
      if (spread > 3000) spread = 3000;
      nc = int'(walk_c) + int'($urandom_range(0, 2 * spread)) - spread;
      ns = int'(walk_s) + int'($urandom_range(0, 2 * spread)) - spread;
      if (nc > 16384) nc = 16384;
      if (nc < -16384) nc = -16384;
      if (ns > 16384) ns = 16384;
      if (ns < -16384) ns = -16384;
      // Pull a shrinking vector back onto the unit circle
      if (nc < 3000 && nc > -3000 && ns < 3000 && ns > -3000) begin
        nc = 16384;
        ns = 0;
      end
      walk_c  = 16'(nc);
      walk_s  = 16'(ns);
      tspread = (board.time_thr > 32'h7FFF_FFFF) ? 32'h0010_0000 : board.time_thr / 16 + 10;
      walk_t  = walk_t + 48'($urandom_range(0, tspread));
      if ($urandom_range(0, 19) == 0) walk_t = walk_t - 48'($urandom_range(1, 5000));
    end
    if ($urandom_range(0, 99) < 15) walk_deg = ~walk_deg;
    r = $urandom_range(0, 9);
    if (r < 4) walk_hes = board.hes_min + 32'($urandom_range(0, 2)) - 32'd1;
    else if (r == 9) walk_hes = $urandom;
    r = $urandom_range(0, 9);
    if (r < 4) walk_sig = board.sig_min + 32'($urandom_range(0, 2)) - 32'd1;
    else if (r == 9) walk_sig = $urandom;
    c = pose(walk_x, walk_y, walk_c, walk_s, walk_t, walk_deg, walk_hes, walk_sig);
  endtask

  task automatic run_phase(input int count, input logic [15:0] trans, input logic [15:0] yaw,
                           input logic [31:0] time_lim, input logic [31:0] hes,
                           input logic [31:0] sig, input logic [2:0] en, input bit stray);
    candidate_t c;
    settle_block();
    if (stray) write_register(CFG_UNUSED_LO, $urandom);
    write_register(CFG_TRANS_THR, {16'($urandom), trans});
    write_register(CFG_YAW_THR, {16'($urandom), yaw});
    write_register(CFG_TIME_THR, time_lim);
    write_register(CFG_HES_MIN, hes);
    write_register(CFG_SIG_MIN, sig);
    write_register(CFG_ENABLES, {29'($urandom), en});
    if (stray) write_register(CFG_UNUSED_HI, $urandom);
    cfg_we_i <= 1'b0;
    settings_used++;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      if (count > 100 && n == count / 2) settle_block();
      random_candidate(c);
      send_candidate(c);
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    settings_used = 1;

    // Directed part under reset defaults
    send_candidate(pose(24'sd0, 24'sd0, 16'sd16384, 16'sd0, 48'd1000, 1'b0, 32'd5, 32'd0));
    // zero rotation vector gives yaw 0
    send_candidate(pose(24'sd0, 24'sd0, 16'sd0, 16'sd0, 48'd1010, 1'b0, 32'd5, 32'd0));
    send_candidate(pose(24'sd0, 24'sd0, 16'sd16384, 16'sd0, 48'd1020, 1'b1, 32'd5, 32'd0));
    send_candidate(pose(24'sd0, 24'sd0, 16'sd16384, 16'sd0, 48'd1030, 1'b1, 32'd5, 32'd0));
    send_candidate(pose(24'sd0, 24'sd0, 16'sd16384, 16'sd0, 48'd1040, 1'b1, 32'd0, 32'd0));
    send_candidate(pose(24'sd0, 24'sd0, 16'sd16384, 16'sd0, 48'd1050, 1'b1, 32'd0,
                        32'hFFFF_FFFF));
    // time going backwards
    send_candidate(pose(24'sd0, 24'sd0, 16'sd16384, 16'sd0, 48'd0, 1'b1, 32'd0,
                        32'hFFFF_FFFF));
    // distance exactly at the threshold, then just below it
    send_candidate(pose(24'sd500, 24'sd0, 16'sd16384, 16'sd0, 48'd1060, 1'b1, 32'd0,
                        32'hFFFF_FFFF));
    send_candidate(pose(24'sd999, 24'sd0, 16'sd16384, 16'sd0, 48'd1070, 1'b1, 32'd0,
                        32'hFFFF_FFFF));
    send_candidate(pose(24'sd999, 24'sd0, 16'sd0, 16'sd16384, 48'd1080, 1'b1, 32'd0,
                        32'hFFFF_FFFF));
    send_candidate(pose(24'sd999, 24'sd0, -16'sd16384, 16'sd0, 48'd1090, 1'b1, 32'd0,
                        32'hFFFF_FFFF));
    // yaw just across the half-turn wrap
    send_candidate(pose(24'sd999, 24'sd0, -16'sd16384, -16'sd1, 48'd1100, 1'b1, 32'd0,
                        32'hFFFF_FFFF));
    // elapsed time exactly at the threshold
    send_candidate(pose(24'sd999, 24'sd0, -16'sd16384, 16'sd0, 48'd1001090, 1'b1, 32'd0,
                        32'hFFFF_FFFF));
    send_candidate(pose(24'h800000, 24'h7FFFFF, -16'sd16384, 16'sd0, 48'd1001100, 1'b1,
                        32'd0, 32'hFFFF_FFFF));
    send_candidate(pose(24'h7FFFFF, 24'h800000, -16'sd16384, 16'sd0, 48'd1001110, 1'b1,
                        32'd0, 32'hFFFF_FFFF));
    send_candidate(pose(24'h7FFFFF, 24'h800000, -16'sd16384, 16'sd0, 48'hFFFF_FFFF_FFFF,
                        1'b1, 32'd0, 32'hFFFF_FFFF));
    send_candidate(pose(24'h7FFFFF, 24'h800000, -16'sd16384, 16'sd0, 48'd0, 1'b0,
                        32'hFFFF_FFFF, 32'd0));
    send_candidate(pose(24'sd0, 24'sd0, 16'sd16384, 16'sd16384, 48'd10, 1'b0, 32'd7, 32'd1));
    send_candidate(pose(24'sd0, 24'sd0, -16'sd16384, -16'sd16384, 48'd20, 1'b0, 32'd7,
                        32'd1));
    send_candidate(pose(24'sd0, 24'sd0, 16'h8000, 16'h7FFF, 48'd30, 1'b0, 32'd7, 32'd1));
    send_candidate(pose(24'sd0, 24'sd0, 16'sd0, -16'sd16384, 48'd40, 1'b0, 32'd7, 32'd1));
    send_candidate(pose(24'sd0, 24'sd0, 16'sd0, -16'sd16384, 48'd50, 1'b1, 32'd7, 32'd1));

    // Random part over several register settings, extremes included
    run_phase(290, 16'd500, 16'd1820, 32'd1000000, 32'h0001_0000, 32'h0002_0000, 3'd7, 1'b0);
    run_phase(30, 16'd0, 16'd1820, 32'd1000000, 32'h0001_0000, 32'h0002_0000, 3'd7, 1'b0);
    run_phase(120, 16'd65535, 16'd32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 3'd7, 1'b0);
    run_phase(40, 16'd65535, 16'd0, 32'd1000000, 32'h0000_8000, 32'h0003_0000, 3'd7, 1'b0);
    run_phase(40, 16'd2000, 16'd32768, 32'd0, 32'h0000_8000, 32'h0003_0000, 3'd7, 1'b0);
    run_phase(150, 16'd800, 16'd3000, 32'd500000, 32'h0001_0000, 32'h0002_0000, 3'd0, 1'b0);
    run_phase(120, 16'd800, 16'd3000, 32'd500000, 32'h0001_0000, 32'h0002_0000, 3'd1, 1'b0);
    run_phase(120, 16'd800, 16'd3000, 32'd500000, 32'h0001_0000, 32'h0002_0000, 3'd2, 1'b0);
    run_phase(120, 16'd800, 16'd3000, 32'd500000, 32'h0001_0000, 32'h0002_0000, 3'd4, 1'b0);
    run_phase(70, 16'd300, 16'd900, 32'd200000, 32'h0000_4000, 32'h0001_0000, 3'd3, 1'b1);
    run_phase(70, 16'd300, 16'd900, 32'd200000, 32'h0000_4000, 32'h0001_0000, 3'd5, 1'b1);
    run_phase(70, 16'd300, 16'd900, 32'd200000, 32'h0000_4000, 32'h0001_0000, 3'd6, 1'b1);
    settle_block();

    $display("Run covered %0d candidates over %0d register settings, %0d keyframes created",
             board.noted, settings_used, board.noted - board.per_reason[0]);
    $display("Reasons: boot %0d dist %0d yaw %0d time %0d degr %0d hess %0d sigma %0d",
             board.per_reason[1], board.per_reason[2], board.per_reason[3],
             board.per_reason[4], board.per_reason[5], board.per_reason[6],
             board.per_reason[7]);
    if (board.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
hdl/kfd_pkg.sv
hdl/kfd_cordic.sv
hdl/kfd_decide.sv
hdl/keyframe_trigger_decider.sv
hdl/kfd_checker.sv
tb/testbench.sv
